/* design/afns_pkg.sv */
// Shared types and constants for the aspect-fill nearest scale address block.
// No dependencies; imported by aspect_fill_nearest_scale_address and the bench.
package afns_pkg;

  localparam int COORD_W = 13;
  localparam int CFG_W   = 14;
  localparam int INDEX_W = 26;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 2'd3;

  localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 14'd1920;
  localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 14'd1080;
  localparam logic [CFG_W-1:0] RST_TARGET_WIDTH  = 14'd1024;
  localparam logic [CFG_W-1:0] RST_TARGET_HEIGHT = 14'd768;

  // setup sequencer: crop size, then the two reciprocals
  typedef enum logic [2:0] {
    ST_PROD,
    ST_CROP_GO,
    ST_CROP_WAIT,
    ST_RW_GO,
    ST_RW_WAIT,
    ST_RH_GO,
    ST_RH_WAIT,
    ST_READY
  } setup_state_t;

endpackage

/* design/aspect_fill_nearest_scale_address.sv */
// Top level of the aspect-fill nearest-neighbor scale address generator.
// Depends on afns_pkg and afns_div.

// Maps destination pixel coordinates to the source pixel sampled when the source
// image is center-cropped to the screen aspect and scaled nearest-neighbor. One
// item per clock is taken and one result per clock delivered while neither
// in_stall nor out_stall holds the flow, through a six-stage pipeline (crop
// multiply, reciprocal multiply, remainder multiply, quotient correction, origin
// add and clamp, row-major index multiply-add). Crop size, crop origin and the
// two reciprocals of the screen dimensions come from a setup sequencer sharing
// one bit-serial divider: after reset and after every configuration write,
// in_stall stays high until its three divisions are done. Dimension registers
// reading zero act as 1, above MAX_DIM as MAX_DIM.
module aspect_fill_nearest_scale_address #(
  parameter int MAX_DIM = 8192
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [afns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afns_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [afns_pkg::COORD_W-1:0]    dest_x,
  input  logic [afns_pkg::COORD_W-1:0]    dest_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [afns_pkg::COORD_W-1:0]    src_x,
  output logic [afns_pkg::COORD_W-1:0]    src_y,
  output logic [afns_pkg::INDEX_W-1:0]    src_pixel_index
);

  import afns_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int EXT_W  = (CFG_W > DIM_W + 1) ? CFG_W : DIM_W + 1;
  localparam int P_W    = COORD_W + DIM_W;   // coordinate times crop size
  localparam int R_W    = P_W + 1;           // reciprocal 2^P_W / dim
  localparam int PROD_W = 2 * DIM_W;
  localparam int NUM_W  = (PROD_W > R_W) ? PROD_W : R_W;
  localparam int STAGES = 6;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [EXT_W-1:0] vx;
    vx = EXT_W'(v);
    if (vx == '0) begin
      return DIM_W'(1);
    end else if (vx > EXT_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(vx);
    end
  endfunction

  // effective dimensions
  logic [DIM_W-1:0] iw, ih, dw, dh;

  always_ff @(posedge clk) begin
    if (rst) begin
      iw <= eff_dim(RST_SOURCE_WIDTH);
      ih <= eff_dim(RST_SOURCE_HEIGHT);
      dw <= eff_dim(RST_TARGET_WIDTH);
      dh <= eff_dim(RST_TARGET_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOURCE_WIDTH:  iw <= eff_dim(cfg_data);
        CFG_SOURCE_HEIGHT: ih <= eff_dim(cfg_data);
        CFG_TARGET_WIDTH:  dw <= eff_dim(cfg_data);
        CFG_TARGET_HEIGHT: dh <= eff_dim(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------- setup sequencer ----------------
  setup_state_t state, state_next;

  logic [PROD_W-1:0] prod_a;   // iw * dh
  logic [PROD_W-1:0] prod_b;   // ih * dw
  logic              wide;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DIM_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [NUM_W-1:0]  one_k;
  logic [DIM_W-1:0]  quo_dim;

  logic [DIM_W-1:0]  crop_w, crop_h, x0, y0;
  logic [R_W-1:0]    rw, rh;

  assign wide    = prod_a > prod_b;
  assign one_k   = NUM_W'(1) << P_W;
  assign quo_dim = DIM_W'(div_quo);

  afns_div #(
    .NUM_W (NUM_W),
    .DEN_W (DIM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PROD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    unique case (state)
      ST_PROD: state_next = ST_CROP_GO;
      ST_CROP_GO: begin
        div_start  = 1'b1;
        div_num    = wide ? NUM_W'(prod_b) : NUM_W'(prod_a);
        div_den    = wide ? dh : dw;
        state_next = ST_CROP_WAIT;
      end
      ST_CROP_WAIT: if (div_done) state_next = ST_RW_GO;
      ST_RW_GO: begin
        div_start  = 1'b1;
        div_num    = one_k;
        div_den    = dw;
        state_next = ST_RW_WAIT;
      end
      ST_RW_WAIT: if (div_done) state_next = ST_RH_GO;
      ST_RH_GO: begin
        div_start  = 1'b1;
        div_num    = one_k;
        div_den    = dh;
        state_next = ST_RH_WAIT;
      end
      ST_RH_WAIT: if (div_done) state_next = ST_READY;
      ST_READY: ;
      default: state_next = ST_PROD;
    endcase
    if (cfg_we) state_next = ST_PROD;
  end

  always_ff @(posedge clk) begin
    if (state == ST_PROD) begin
      prod_a <= PROD_W'(iw) * PROD_W'(dh);
      prod_b <= PROD_W'(ih) * PROD_W'(dw);
    end
    if (div_done) begin
      if (state == ST_CROP_WAIT) begin
        if (wide) begin
          crop_w <= quo_dim;
          crop_h <= ih;
          x0     <= DIM_W'((iw - quo_dim) >> 1);
          y0     <= '0;
        end else begin
          crop_w <= iw;
          crop_h <= quo_dim;
          x0     <= '0;
          y0     <= DIM_W'((ih - quo_dim) >> 1);
        end
      end
      if (state == ST_RW_WAIT) rw <= R_W'(div_quo);
      if (state == ST_RH_WAIT) rh <= R_W'(div_quo);
    end
  end

  // ---------------- item pipeline ----------------
  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;
  logic              in_accept;

  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall  = (state != ST_READY) || !en[0];
  assign in_accept = in_valid && !in_stall;
  assign out_valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_accept;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: coordinate times crop size
  logic [P_W-1:0] s1_px, s1_py;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_px <= P_W'(dest_x) * P_W'(crop_w);
      s1_py <= P_W'(dest_y) * P_W'(crop_h);
    end
  end

  // stage 2: quotient estimate by reciprocal, low by at most one
  logic [P_W+R_W-1:0] mx, my;
  logic [P_W-1:0]     s2_px, s2_py, s2_qx, s2_qy;
  assign mx = (P_W+R_W)'(s1_px) * (P_W+R_W)'(rw);
  assign my = (P_W+R_W)'(s1_py) * (P_W+R_W)'(rh);
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_px <= s1_px;
      s2_py <= s1_py;
      s2_qx <= mx[2*P_W-1:P_W];
      s2_qy <= my[2*P_W-1:P_W];
    end
  end

  // stage 3: estimate times divisor
  logic [P_W+DIM_W-1:0] tx, ty;
  logic [P_W-1:0]       s3_px, s3_py, s3_qx, s3_qy, s3_tx, s3_ty;
  assign tx = (P_W+DIM_W)'(s2_qx) * (P_W+DIM_W)'(dw);
  assign ty = (P_W+DIM_W)'(s2_qy) * (P_W+DIM_W)'(dh);
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_px <= s2_px;
      s3_py <= s2_py;
      s3_qx <= s2_qx;
      s3_qy <= s2_qy;
      s3_tx <= tx[P_W-1:0];
      s3_ty <= ty[P_W-1:0];
    end
  end

  // stage 4: correct the estimate when the remainder reaches the divisor
  logic [P_W-1:0] rx, ry;
  logic [P_W-1:0] s4_qx, s4_qy;
  assign rx = s3_px - s3_tx;
  assign ry = s3_py - s3_ty;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_qx <= s3_qx + P_W'(rx >= P_W'(dw));
      s4_qy <= s3_qy + P_W'(ry >= P_W'(dh));
    end
  end

  // stage 5: add crop origin, clamp to image
  logic [P_W:0]     sum_x, sum_y;
  logic [DIM_W-1:0] s5_sx, s5_sy;
  assign sum_x = (P_W+1)'(x0) + (P_W+1)'(s4_qx);
  assign sum_y = (P_W+1)'(y0) + (P_W+1)'(s4_qy);
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_sx <= (sum_x >= (P_W+1)'(iw)) ? iw - DIM_W'(1) : DIM_W'(sum_x);
      s5_sy <= (sum_y >= (P_W+1)'(ih)) ? ih - DIM_W'(1) : DIM_W'(sum_y);
    end
  end

  // stage 6: row-major index
  logic [PROD_W:0]   idx;
  logic [DIM_W-1:0]  s6_sx, s6_sy;
  logic [INDEX_W-1:0] s6_idx;
  assign idx = (PROD_W+1)'(s5_sy) * (PROD_W+1)'(iw) + (PROD_W+1)'(s5_sx);
  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_sx  <= s5_sx;
      s6_sy  <= s5_sy;
      s6_idx <= INDEX_W'(idx);
    end
  end

  assign src_x           = COORD_W'(s6_sx);
  assign src_y           = COORD_W'(s6_sy);
  assign src_pixel_index = s6_idx;

`ifndef SYNTHESIS
  a_setup_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state != ST_READY) |-> in_stall)
    else $error("item accepted while crop setup is running");

  a_cfg_restarts_setup: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (state == ST_PROD))
    else $error("configuration write did not restart setup");

  a_crop_in_image: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READY) |-> (crop_w <= iw && crop_h <= ih &&
                             x0 <= iw - crop_w && y0 <= ih - crop_h))
    else $error("crop window outside source image");

  a_result_clamped: assert property (@(posedge clk) disable iff (rst)
    v[STAGES-1] |-> (s6_sx < iw && s6_sy < ih))
    else $error("source coordinate beyond image bounds");
`endif

endmodule

/* design/afns_div.sv */
// Iterative restoring divider, one quotient bit per clock.
// Used by aspect_fill_nearest_scale_address for its setup divisions; no dependencies.
module afns_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, work[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};
  assign quo    = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      work <= {work[NUM_W-2:0], fits};
      if (fits) begin
        rem <= DEN_W'(rem_sh - {1'b0, den_q});
      end else begin
        rem <= rem_sh[DEN_W-1:0];
      end
    end
  end

endmodule

/* bench/afns_scoreboard.sv */
`timescale 1ns / 1ps
// Scoreboard for aspect_fill_nearest_scale_address: tracks the dimension registers,
// predicts the sampled source pixel of every accepted item and checks results in order.
// Depends on afns_pkg for port widths, register indexes and reset values.
module afns_scoreboard #(
  parameter int MAX_DIM = 8192
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [afns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afns_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [afns_pkg::COORD_W-1:0]   dest_x,
  input  logic [afns_pkg::COORD_W-1:0]   dest_y,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [afns_pkg::COORD_W-1:0]   src_x,
  input  logic [afns_pkg::COORD_W-1:0]   src_y,
  input  logic [afns_pkg::INDEX_W-1:0]   src_pixel_index,
  output int                             error_count,
  output int                             pending
);
  import afns_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [INDEX_W-1:0] pixel;
  } src_pixel_t;

  logic [CFG_W-1:0] img_w, img_h, scr_w, scr_h;
  src_pixel_t       sample_q[$];

  // zero reads as 1, anything above MAX_DIM saturates
  function automatic longint unsigned usable_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return longint'(v);
  endfunction

  function automatic src_pixel_t sample_of(input logic [COORD_W-1:0] dx,
                                           input logic [COORD_W-1:0] dy);
    longint unsigned iw, ih, dw, dh, cw, ch, x0, y0, sx, sy, idx;
    src_pixel_t p;
    iw = usable_dim(img_w);
    ih = usable_dim(img_h);
    dw = usable_dim(scr_w);
    dh = usable_dim(scr_h);
    if (iw * dh > ih * dw) begin
      // image wider than screen: trim left and right
      ch = ih;
      cw = (ih * dw) / dh;
      x0 = (iw - cw) / 2;
      y0 = 0;
    end else begin
      cw = iw;
      ch = (iw * dh) / dw;
      x0 = 0;
      y0 = (ih - ch) / 2;
    end
    sx = x0 + (longint'(dx) * cw) / dw;
    if (sx >= iw) sx = iw - 1;
    sy = y0 + (longint'(dy) * ch) / dh;
    if (sy >= ih) sy = ih - 1;
    idx = sy * iw + sx;
    p.col   = sx[COORD_W-1:0];
    p.row   = sy[COORD_W-1:0];
    p.pixel = idx[INDEX_W-1:0];
    return p;
  endfunction

  task automatic check_field(input string name, input logic [INDEX_W-1:0] want,
                             input logic [INDEX_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    src_pixel_t want;
    if (rst) begin
      img_w = RST_SOURCE_WIDTH;
      img_h = RST_SOURCE_HEIGHT;
      scr_w = RST_TARGET_WIDTH;
      scr_h = RST_TARGET_HEIGHT;
      sample_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE_WIDTH:  img_w = cfg_data;
          CFG_SOURCE_HEIGHT: img_h = cfg_data;
          CFG_TARGET_WIDTH:  scr_w = cfg_data;
          CFG_TARGET_HEIGHT: scr_h = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        sample_q.push_back(sample_of(dest_x, dest_y));
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected item, expected none, got x=%0d y=%0d index=%0d",
                   $time, src_x, src_y, src_pixel_index);
        end else begin
          want = sample_q.pop_front();
          check_field("src_x", INDEX_W'(want.col), INDEX_W'(src_x));
          check_field("src_y", INDEX_W'(want.row), INDEX_W'(src_y));
          check_field("src_pixel_index", want.pixel, src_pixel_index);
        end
      end
      pending <= sample_q.size();
    end
  end

endmodule

/* bench/aspect_fill_nearest_scale_address_tb.sv */
`timescale 1ns / 1ps
// Top of the aspect_fill_nearest_scale_address bench: clock, reset, register writes,
// coordinate stimulus and output back-pressure; checking is done in afns_scoreboard.
// Depends on afns_pkg, the block itself and afns_scoreboard.
module aspect_fill_nearest_scale_address_tb;
  import afns_pkg::*;

  localparam int MAX_DIM = 8192;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [COORD_W-1:0]   dest_x;
  logic [COORD_W-1:0]   dest_y;
  logic                 out_valid;
  logic                 out_stall;
  logic [COORD_W-1:0]   src_x;
  logic [COORD_W-1:0]   src_y;
  logic [INDEX_W-1:0]   src_pixel_index;
  logic                 hold_req;
  int                   error_count;
  int                   pending;
  int                   n_items;
  int                   n_settings;
  int                   scr_w_set;
  int                   scr_h_set;

  aspect_fill_nearest_scale_address #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .dest_x(dest_x), .dest_y(dest_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .src_x(src_x), .src_y(src_y), .src_pixel_index(src_pixel_index)
  );

  afns_scoreboard #(.MAX_DIM(MAX_DIM)) scoreboard (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .dest_x(dest_x), .dest_y(dest_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .src_x(src_x), .src_y(src_y), .src_pixel_index(src_pixel_index),
    .error_count(error_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // mostly none or short, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int screen_span(input int v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 18) return $urandom_range(MAX_DIM + 1, 16383);
    if (r < 35) return $urandom_range(1, 16);
    return $urandom_range(1, MAX_DIM);
  endfunction

  // output side back-pressure, with one long hold-off on request
  initial begin
    int hold_left, busy_left, free_left;
    bit hold_done;
    hold_left = 0;
    busy_left = 0;
    free_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (busy_left > 0) begin
        out_stall <= 1'b1;
        busy_left--;
      end else if (free_left > 0) begin
        out_stall <= 1'b0;
        free_left--;
      end else begin
        busy_left = idle_gap();
        free_left = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(0, 6);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input int x, input int y, input bit gapless);
    int gap;
    in_valid <= 1'b1;
    dest_x   <= COORD_W'(x);
    dest_y   <= COORD_W'(y);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    gap = gapless ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every item has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(v);
    @(posedge clk);
  endtask

  task automatic set_dims(input int sw, input int sh, input int tw, input int th);
    drain();
    cfg_write(CFG_SOURCE_WIDTH, sw);
    cfg_write(CFG_SOURCE_HEIGHT, sh);
    cfg_write(CFG_TARGET_WIDTH, tw);
    cfg_write(CFG_TARGET_HEIGHT, th);
    cfg_we <= 1'b0;
    scr_w_set = tw;
    scr_h_set = th;
    n_settings++;
  endtask

  task automatic run_phase(input int n, input bit corners, input bit gapless,
                           input bit long_hold, input bit pause_mid);
    int w, h, x, y;
    w = screen_span(scr_w_set);
    h = screen_span(scr_h_set);
    if (corners) begin
      send_item(0, 0, gapless);
      send_item(w - 1, h - 1, gapless);
      send_item(8191, 8191, gapless);
    end
    for (int i = 0; i < n; i++) begin
      if (long_hold && i == 20) hold_req <= 1'b1;
      if (pause_mid && i == n / 2) drain();
      // a fifth of the items may land past the screen edge
      if ($urandom_range(0, 4) == 0) begin
        x = $urandom_range(0, 8191);
        y = $urandom_range(0, 8191);
      end else begin
        x = $urandom_range(0, (w > 8192 ? 8192 : w) - 1);
        y = $urandom_range(0, (h > 8192 ? 8192 : h) - 1);
      end
      send_item(x, y, gapless);
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_SOURCE_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    dest_x    = '0;
    dest_y    = '0;
    hold_req  = 1'b0;
    n_items   = 0;
    n_settings = 1;
    scr_w_set = int'(RST_TARGET_WIDTH);
    scr_h_set = int'(RST_TARGET_HEIGHT);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset dimensions: edges, screen corner, just past it, alternating bits
    send_item(0, 0, 1'b0);
    send_item(8191, 8191, 1'b0);
    send_item(1023, 767, 1'b0);
    send_item(1024, 768, 1'b0);
    send_item(0, 8191, 1'b0);
    send_item(8191, 0, 1'b0);
    send_item(511, 383, 1'b0);
    send_item(13'h1555, 13'h0AAA, 1'b0);
    send_item(13'h0AAA, 13'h1555, 1'b0);
    send_item(1, 1, 1'b0);
    run_phase(110, 1'b0, 1'b0, 1'b0, 1'b0);

    set_dims(1, 1, 1, 1);
    run_phase(110, 1'b1, 1'b0, 1'b0, 1'b0);
    set_dims(8192, 8192, 8192, 8192);
    run_phase(110, 1'b1, 1'b1, 1'b1, 1'b0);
    // zero registers act as 1
    set_dims(0, 700, 640, 0);
    run_phase(110, 1'b1, 1'b0, 1'b0, 1'b0);
    // oversized registers saturate
    set_dims(16383, 9000, 12000, 16383);
    run_phase(110, 1'b1, 1'b0, 1'b0, 1'b0);
    set_dims(1080, 1920, 1024, 768);
    run_phase(110, 1'b0, 1'b0, 1'b0, 1'b1);
    set_dims(640, 480, 320, 240);
    run_phase(110, 1'b0, 1'b0, 1'b0, 1'b0);
    set_dims(8192, 1, 1, 8192);
    run_phase(110, 1'b0, 1'b0, 1'b0, 1'b0);
    set_dims(1, 8192, 8192, 1);
    run_phase(110, 1'b0, 1'b0, 1'b0, 1'b0);
    for (int k = 0; k < 6; k++) begin
      set_dims(pick_dim(), pick_dim(), pick_dim(), pick_dim());
      run_phase(110, 1'b0, k == 2, 1'b0, 1'b0);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d coordinate items over %0d image/screen settings,", n_items,
             n_settings);
    $display("incl. zero and oversized registers and coordinates past the screen edge.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* aspect_fill_nearest_scale_address.f */
design/afns_pkg.sv
design/afns_div.sv
design/aspect_fill_nearest_scale_address.sv
bench/afns_scoreboard.sv
bench/aspect_fill_nearest_scale_address_tb.sv
